FILE: hdl/pct_pkg.sv
// Shared constants for the 2D pair collision test core.
// No dependencies.
package pct_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic SHAPE_CIRCLE = 1'b0;
    localparam logic SHAPE_RECT   = 1'b1;

    localparam logic [1:0] KIND_CC = 2'd0;
    localparam logic [1:0] KIND_RR = 2'd1;
    localparam logic [1:0] KIND_RC = 2'd2;

endpackage

FILE: hdl/pct_front.sv
// Front end: orders the pair, takes center deltas, classifies the test.
// Rectangle pairs are finished here; round tests leave as vector and limit.
// Depends on pct_pkg.
module pct_front #(
    parameter int CB = pct_pkg::COORD_BITS_DEF,
    parameter int FB = pct_pkg::FRAC_BITS_DEF,
    parameter int EW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_shape_first,
    input  logic signed [CB-1:0] i_center_x_first,
    input  logic signed [CB-1:0] i_center_y_first,
    input  logic        [CB-2:0] i_size_x_first,
    input  logic        [CB-2:0] i_size_y_first,
    input  logic                 i_shape_second,
    input  logic signed [CB-1:0] i_center_x_second,
    input  logic signed [CB-1:0] i_center_y_second,
    input  logic        [CB-2:0] i_size_x_second,
    input  logic        [CB-2:0] i_size_y_second,
    output logic                 o_push,
    output logic        [EW-1:0] o_entry
);
    import pct_pkg::*;

    typedef struct packed {
        logic                 rect;
        logic                 rhit;
        logic signed [FB+1:0] rnx;
        logic signed [FB+1:0] rny;
        logic        [CB-2:0] rpen;
        logic                 sx;
        logic                 sy;
        logic        [CB-1:0] mx;
        logic        [CB-1:0] my;
        logic        [CB-1:0] radius;
        logic                 zx_one;
        logic        [CB-2:0] zpen;
        logic                 swapped;
    } t_entry;

    localparam logic signed [FB+1:0] ONE = (FB+2)'(1) << FB;
    localparam logic [CB+1:0] PEN_MAX = (CB+2)'({(CB-1){1'b1}});

    logic               r_v, n_v;
    logic [1:0]         r_kind, n_kind;
    logic signed [CB:0] r_dx, n_dx, r_dy, n_dy;
    logic [CB-2:0]      r_aw, n_aw, r_ah, n_ah, r_bw, n_bw, r_bh, n_bh;
    logic               r_swp, n_swp;

    logic signed [CB-1:0] ax, ay, bx, by;
    logic                 swp;

    always_comb begin
        swp = (i_shape_first == SHAPE_CIRCLE) && (i_shape_second == SHAPE_RECT);
        ax = swp ? i_center_x_second : i_center_x_first;
        ay = swp ? i_center_y_second : i_center_y_first;
        bx = swp ? i_center_x_first : i_center_x_second;
        by = swp ? i_center_y_first : i_center_y_second;
        n_aw = swp ? i_size_x_second : i_size_x_first;
        n_ah = swp ? i_size_y_second : i_size_y_first;
        n_bw = swp ? i_size_x_first : i_size_x_second;
        n_bh = swp ? i_size_y_first : i_size_y_second;
        n_dx = {bx[CB-1], bx} - {ax[CB-1], ax};
        n_dy = {by[CB-1], by} - {ay[CB-1], ay};
        n_swp = swp;
        n_v = i_accept;
        if (i_shape_first == SHAPE_CIRCLE && i_shape_second == SHAPE_CIRCLE) begin
            n_kind = KIND_CC;
        end else if (i_shape_first == SHAPE_RECT && i_shape_second == SHAPE_RECT) begin
            n_kind = KIND_RR;
        end else begin
            n_kind = KIND_RC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_kind <= n_kind;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_aw   <= n_aw;
        r_ah   <= n_ah;
        r_bw   <= n_bw;
        r_bh   <= n_bh;
        r_swp  <= n_swp;
    end

    logic        [CB:0]   adx, ady;
    logic signed [CB+1:0] ox, oy;
    logic signed [CB:0]   aws, ahs, vx, vy;
    logic        [CB:0]   avx, avy;
    t_entry               e;

    always_comb begin
        adx = r_dx[CB] ? (CB+1)'(-r_dx) : (CB+1)'(r_dx);
        ady = r_dy[CB] ? (CB+1)'(-r_dy) : (CB+1)'(r_dy);
        ox = $signed({3'b000, r_aw} + {3'b000, r_bw} - {1'b0, adx});
        oy = $signed({3'b000, r_ah} + {3'b000, r_bh} - {1'b0, ady});
        aws = $signed({2'b00, r_aw});
        ahs = $signed({2'b00, r_ah});
        e = '0;
        e.swapped = r_swp;
        unique case (r_kind)
            KIND_RR: begin
                e.rect = 1'b1;
                e.rhit = (ox > 0) && (oy > 0);
                if (e.rhit) begin
                    if (ox > oy) begin
                        e.rpen = ($unsigned(oy) > PEN_MAX) ? PEN_MAX[CB-2:0] : oy[CB-2:0];
                        e.rny  = r_dy[CB] ? -ONE : ONE;
                    end else begin
                        e.rpen = ($unsigned(ox) > PEN_MAX) ? PEN_MAX[CB-2:0] : ox[CB-2:0];
                        e.rnx  = r_dx[CB] ? -ONE : ONE;
                    end
                end
                vx = '0;
                vy = '0;
            end
            KIND_CC: begin
                vx = r_dx;
                vy = r_dy;
                e.radius = {1'b0, r_aw} + {1'b0, r_bw};
                e.zx_one = 1'b1;
                e.zpen   = r_aw;
            end
            default: begin
                if (r_dx > aws) begin
                    vx = r_dx - aws;
                end else if (r_dx < -aws) begin
                    vx = r_dx + aws;
                end else begin
                    vx = '0;
                end
                if (r_dy > ahs) begin
                    vy = r_dy - ahs;
                end else if (r_dy < -ahs) begin
                    vy = r_dy + ahs;
                end else begin
                    vy = '0;
                end
                e.radius = {1'b0, r_bw};
                e.zx_one = 1'b0;
                e.zpen   = r_bw;
            end
        endcase
        avx  = vx[CB] ? (CB+1)'(-vx) : (CB+1)'(vx);
        avy  = vy[CB] ? (CB+1)'(-vy) : (CB+1)'(vy);
        e.sx = vx[CB];
        e.sy = vy[CB];
        e.mx = avx[CB-1:0];
        e.my = avy[CB-1:0];
    end

    assign o_push  = r_v;
    assign o_entry = EW'(e);

endmodule

FILE: hdl/pct_queue.sv
// Short queue between front and back ends; head is read every cycle it holds data.
// Depends on pct_pkg.
module pct_queue #(
    parameter int W     = 8,
    parameter int DEPTH = pct_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic         o_busy
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          pop;

    assign pop = (r_cnt != '0);

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = pop;
    assign o_data  = r_mem[r_rp];
    assign o_busy  = (r_cnt >= (AW+1)'(DEPTH-1));

endmodule

FILE: hdl/pct_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor result.
// No dependencies.
module pct_sqrt #(
    parameter int SW = 16,
    parameter int RB = 8
) (
    input  logic          i_clk,
    input  logic [SW-1:0] i_s,
    output logic [RB-1:0] o_root
);
    localparam int TW = 2 * RB;

    logic [TW-1:0] r_rem [RB+1];
    logic [RB-1:0] r_res [RB+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= TW'(i_s);
        r_res[0] <= '0;
    end

    for (genvar i = 0; i < RB; i++) begin : g_stage
        localparam int B = RB - 1 - i;
        logic [TW-1:0] term;
        assign term = (TW'(r_res[i]) << (B + 1)) | (TW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (term <= r_rem[i]) begin
                r_rem[i+1] <= r_rem[i] - term;
                r_res[i+1] <= r_res[i] | (RB'(1) << B);
            end else begin
                r_rem[i+1] <= r_rem[i];
                r_res[i+1] <= r_res[i];
            end
        end
    end

    assign o_root = r_res[RB];

endmodule

FILE: hdl/pct_div.sv
// Pipelined restoring divider for one unit-normal component, rounded to nearest.
// No dependencies.
module pct_div #(
    parameter int CB = 32,
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic [CB-1:0] i_m,
    input  logic [CB:0]   i_dist,
    output logic [FB:0]   o_q
);
    localparam int N = FB + 1;

    logic [CB+1:0] r_r   [N+1];
    logic [FB+1:0] r_acc [N+1];
    logic [CB:0]   r_d   [N+1];

    always_ff @(posedge i_clk) begin
        if ({1'b0, i_m} >= i_dist) begin
            r_r[0]   <= (CB+2)'({1'b0, i_m} - i_dist);
            r_acc[0] <= (FB+2)'(1);
        end else begin
            r_r[0]   <= (CB+2)'(i_m);
            r_acc[0] <= '0;
        end
        r_d[0] <= i_dist;
    end

    for (genvar j = 0; j < N; j++) begin : g_step
        logic [CB+1:0] sh;
        assign sh = r_r[j] << 1;
        always_ff @(posedge i_clk) begin
            r_d[j+1] <= r_d[j];
            if (sh >= (CB+2)'(r_d[j])) begin
                r_r[j+1]   <= sh - (CB+2)'(r_d[j]);
                r_acc[j+1] <= {r_acc[j][FB:0], 1'b1};
            end else begin
                r_r[j+1]   <= sh;
                r_acc[j+1] <= {r_acc[j][FB:0], 1'b0};
            end
        end
    end

    logic [FB+1:0] rnd;
    assign rnd  = r_acc[N] + (FB+2)'(1);
    assign o_q  = rnd[FB+1:1];

endmodule

FILE: hdl/pct_back.sv
// Back end: squared distance test, square root, normal division and result register.
// Depends on pct_pkg, pct_sqrt and pct_div.
module pct_back #(
    parameter int CB = pct_pkg::COORD_BITS_DEF,
    parameter int FB = pct_pkg::FRAC_BITS_DEF,
    parameter int EW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic        [EW-1:0] i_entry,
    output logic                 o_strobe,
    output logic                 o_hit,
    output logic signed [FB+1:0] o_normal_x,
    output logic signed [FB+1:0] o_normal_y,
    output logic        [CB-2:0] o_penetration,
    output logic                 o_swapped
);
    import pct_pkg::*;

    typedef struct packed {
        logic                 rect;
        logic                 rhit;
        logic signed [FB+1:0] rnx;
        logic signed [FB+1:0] rny;
        logic        [CB-2:0] rpen;
        logic                 sx;
        logic                 sy;
        logic        [CB-1:0] mx;
        logic        [CB-1:0] my;
        logic        [CB-1:0] radius;
        logic                 zx_one;
        logic        [CB-2:0] zpen;
        logic                 swapped;
    } t_entry;

    typedef struct packed {
        t_entry      e;
        logic        hitr;
        logic        zero;
        logic [CB:0] len;
    } t_side;

    localparam int RB = CB + 1;
    localparam int SW = 2 * CB + 1;
    localparam int DL = FB + 2;
    localparam logic signed [FB+1:0] ONE = (FB+2)'(1) << FB;

    t_entry          in_e;
    logic            r_v1, r_v2;
    t_entry          r_e1, r_e2;
    logic [2*CB-1:0] r_sqx, r_sqy, r_sqr;
    logic [SW-1:0]   r_s;
    logic            r_hitr, r_zero;

    assign in_e = t_entry'(i_entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_e1   <= in_e;
        r_sqx  <= in_e.mx * in_e.mx;
        r_sqy  <= in_e.my * in_e.my;
        r_sqr  <= in_e.radius * in_e.radius;
        r_e2   <= r_e1;
        r_s    <= SW'(r_sqx) + SW'(r_sqy);
        r_hitr <= (SW'(r_sqx) + SW'(r_sqy)) <= SW'(r_sqr);
        r_zero <= (r_sqx == '0) && (r_sqy == '0);
    end

    logic [RB-1:0] root;
    pct_sqrt #(.SW(SW), .RB(RB)) u_sqrt (
        .i_clk  (i_clk),
        .i_s    (r_s),
        .o_root (root)
    );

    t_side        r_sd1 [RB+1];
    logic [RB:0]  r_vd1;
    t_side        sd1_in, sd2_in;
    t_side        r_sd2 [DL];
    logic [DL-1:0] r_vd2;

    always_comb begin
        sd1_in      = '0;
        sd1_in.e    = r_e2;
        sd1_in.hitr = r_hitr;
        sd1_in.zero = r_zero;
        sd2_in      = r_sd1[RB];
        sd2_in.len  = root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd1 <= '0;
            r_vd2 <= '0;
        end else begin
            r_vd1 <= {r_vd1[RB-1:0], r_v2};
            r_vd2 <= {r_vd2[DL-2:0], r_vd1[RB]};
        end
        r_sd1[0] <= sd1_in;
        for (int k = 1; k <= RB; k++) begin
            r_sd1[k] <= r_sd1[k-1];
        end
        r_sd2[0] <= sd2_in;
        for (int k = 1; k < DL; k++) begin
            r_sd2[k] <= r_sd2[k-1];
        end
    end

    logic [FB:0] qx, qy;
    pct_div #(.CB(CB), .FB(FB)) u_div_x (
        .i_clk  (i_clk),
        .i_m    (r_sd1[RB].e.mx),
        .i_dist (root),
        .o_q    (qx)
    );
    pct_div #(.CB(CB), .FB(FB)) u_div_y (
        .i_clk  (i_clk),
        .i_m    (r_sd1[RB].e.my),
        .i_dist (root),
        .o_q    (qy)
    );

    t_side                s;
    logic                 n_hit;
    logic signed [FB+1:0] n_nx, n_ny, ux, uy;
    logic        [CB-2:0] n_pen;
    logic        [CB-1:0] diff;

    always_comb begin
        s     = r_sd2[DL-1];
        ux    = $signed({1'b0, qx});
        uy    = $signed({1'b0, qy});
        diff  = s.e.radius - s.len[CB-1:0];
        n_hit = 1'b0;
        n_nx  = '0;
        n_ny  = '0;
        n_pen = '0;
        if (s.e.rect) begin
            n_hit = s.e.rhit;
            n_nx  = s.e.rnx;
            n_ny  = s.e.rny;
            n_pen = s.e.rpen;
        end else if (s.hitr) begin
            n_hit = 1'b1;
            if (s.zero) begin
                n_nx  = s.e.zx_one ? ONE : '0;
                n_ny  = s.e.zx_one ? '0 : ONE;
                n_pen = s.e.zpen;
            end else begin
                n_nx  = s.e.sx ? -ux : ux;
                n_ny  = s.e.sy ? -uy : uy;
                n_pen = diff[CB-1] ? {(CB-1){1'b1}} : diff[CB-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vd2[DL-1];
        end
        o_hit         <= n_hit;
        o_normal_x    <= n_nx;
        o_normal_y    <= n_ny;
        o_penetration <= n_pen;
        o_swapped     <= s.e.swapped;
    end

endmodule

FILE: hdl/pair_collision_test_2d_core.sv
// Top level of the 2D pair collision test: front end, queue, back end.
// Depends on pct_pkg, pct_front, pct_queue, pct_back.
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+-----------------------------
//  pair in  | start, busy, i_shape_*, i_center_*, ...| start high while busy low
//  result   | o_strobe, o_hit, o_normal_*, ...       | one cycle while o_strobe high
//
// One pair per cycle while busy is low; the square root and normal dividers are
// pipelined, one result bit per stage.
// Synchronous active-low reset clears the valid pipeline and queue pointers.
// The back end never stalls; busy rises only if the queue nears full.
module pair_collision_test_2d_core #(
    parameter int COORD_BITS = pct_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pct_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_shape_first,
    input  logic signed [COORD_BITS-1:0] i_center_x_first,
    input  logic signed [COORD_BITS-1:0] i_center_y_first,
    input  logic        [COORD_BITS-2:0] i_size_x_first,
    input  logic        [COORD_BITS-2:0] i_size_y_first,
    input  logic                         i_shape_second,
    input  logic signed [COORD_BITS-1:0] i_center_x_second,
    input  logic signed [COORD_BITS-1:0] i_center_y_second,
    input  logic        [COORD_BITS-2:0] i_size_x_second,
    input  logic        [COORD_BITS-2:0] i_size_y_second,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic signed [FRAC_BITS+1:0]  o_normal_x,
    output logic signed [FRAC_BITS+1:0]  o_normal_y,
    output logic        [COORD_BITS-2:0] o_penetration,
    output logic                         o_swapped
);
    import pct_pkg::*;

    localparam int EW = 2 + 2 * (FRAC_BITS + 2) + (COORD_BITS - 1) + 2
                      + 3 * COORD_BITS + 1 + (COORD_BITS - 1) + 1;

    logic          push, q_valid;
    logic [EW-1:0] push_entry, head_entry;

    pct_front #(.CB(COORD_BITS), .FB(FRAC_BITS), .EW(EW)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (start && !busy),
        .i_shape_first     (i_shape_first),
        .i_center_x_first  (i_center_x_first),
        .i_center_y_first  (i_center_y_first),
        .i_size_x_first    (i_size_x_first),
        .i_size_y_first    (i_size_y_first),
        .i_shape_second    (i_shape_second),
        .i_center_x_second (i_center_x_second),
        .i_center_y_second (i_center_y_second),
        .i_size_x_second   (i_size_x_second),
        .i_size_y_second   (i_size_y_second),
        .o_push            (push),
        .o_entry           (push_entry)
    );

    pct_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_valid (q_valid),
        .o_data  (head_entry),
        .o_busy  (busy)
    );

    pct_back #(.CB(COORD_BITS), .FB(FRAC_BITS), .EW(EW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_entry       (head_entry),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_penetration (o_penetration),
        .o_swapped     (o_swapped)
    );

endmodule

FILE: hdl/pct_check.sv
// Port-level checks for the 2D pair collision test core, bound to the top level.
// Depends on pct_pkg and pair_collision_test_2d_core.
module pct_check #(
    parameter int CB = pct_pkg::COORD_BITS_DEF,
    parameter int FB = pct_pkg::FRAC_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_strobe,
    input logic                 o_hit,
    input logic signed [FB+1:0] o_normal_x,
    input logic signed [FB+1:0] o_normal_y,
    input logic        [CB-2:0] o_penetration,
    input logic                 o_swapped
);
    localparam logic signed [FB+1:0] ONE = (FB+2)'(1) << FB;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe && !busy)
        else $error("strobe or busy after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_normal_x == '0 && o_normal_y == '0 && o_penetration == '0)
        else $error("miss with nonzero contact");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_normal_x <= ONE && o_normal_x >= -ONE
                  && o_normal_y <= ONE && o_normal_y >= -ONE)
        else $error("normal out of unit range");

    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hit |-> o_normal_x != '0 || o_normal_y != '0)
        else $error("hit with zero normal");

endmodule

bind pair_collision_test_2d_core pct_check #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_pct_check (.*);
